FILE: src/bcrq_pkg.sv
// Shared types and constants for the bitcrusher rate reduce and quantize unit.
package bcrq_pkg;

   localparam int LEVEL_BITS = 16;
   localparam int STEP_BITS  = 32;
   localparam int PHASE_BITS = 28;
   localparam int VMAG_BITS  = LEVEL_BITS + 1;
   localparam int CSR_BITS   = 32;

   typedef enum logic [0:0] {
      CSR_QUANT_LEVELS = 1'b0,
      CSR_PHASE_STEP   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  start;
      logic [VMAG_BITS-1:0]  dividend;
      logic [LEVEL_BITS-1:0] divisor;
   } div_req_type;

endpackage

FILE: src/bitcrush_rate_reduce_quantize_unit.sv
// Top level: per-channel sample-and-hold rate reducer and amplitude quantiser.
//
// Input items (req_chan, req_sample_in) arrive on a valid/stall channel; each
// gives exactly one result item (rsp_sample_out) on the rsp_ channel.
// Each channel keeps a Q0.28 phase and a held sample. The phase advances by
// phase_step per item; on a carry past 1.0 the input is captured. The held
// value is scaled by quant_levels, rounded, truncated and divided back.
// One item is in flight at a time; req_stall is high from acceptance until
// the result is loaded into the output register, so a new item is taken
// only after the last one is through, at a spacing set mostly by the divide of the
// level by quant_levels in the shared compare-subtract unit, one quotient bit
// per cycle.
// The output register lets a new item be accepted while a result waits under
// rsp_stall; that item then waits at the end of its work until the register
// is free, and the stalled result holds steady.
// Reset (synchronous, active high) clears phases and held samples to zero and
// loads quant_levels = 32768, phase_step = 1.0. csr_ writes are registered.
module bitcrush_rate_reduce_quantize_unit #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_chan,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                         csr_write,
   input  bcrq_pkg::csr_index_type      csr_index,
   input  logic [bcrq_pkg::CSR_BITS-1:0] csr_data
);
   import bcrq_pkg::*;

   localparam int FRAC      = SAMPLE_BITS - 1;
   localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_BITS = SAMPLE_BITS + VMAG_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_MULT,
      ST_SCALE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff;

   logic [LEVEL_BITS-1:0] levels_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [PHASE_BITS-1:0] phase_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] held_ff [CHANNELS];

   logic [IDX_BITS-1:0]           idx_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [LEVEL_BITS-1:0]         lev_ff;
   logic signed [SAMPLE_BITS-1:0] h_ff;
   logic signed [PROD_BITS-1:0]   x_ff;
   logic                          neg_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_ff;

   logic                          accept;
   logic [IDX_BITS-1:0]           idx_in;
   logic [STEP_BITS:0]            phase_sum;
   logic                          capture;
   logic signed [PROD_BITS-1:0]   prod;
   logic [PROD_BITS-1:0]          mag;
   div_req_type                   div_req;
   logic                          div_done;
   logic [SAMPLE_BITS-1:0]        quot;
   logic [SAMPLE_BITS-1:0]        ymag;
   logic signed [SAMPLE_BITS-1:0] y_in;
   logic                          out_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_in    = (int'(req_chan) >= CHANNELS) ? IDX_BITS'(CHANNELS - 1)
                                                   : IDX_BITS'(req_chan);

   assign phase_sum = {{(STEP_BITS + 1 - PHASE_BITS){1'b0}}, phase_ff[idx_ff]}
                    + {1'b0, step_ff};
   assign capture   = |phase_sum[STEP_BITS:PHASE_BITS];

   assign prod = $signed(h_ff) * $signed({1'b0, lev_ff})
               + (PROD_BITS'(1) <<< (FRAC - 1));

   assign mag = x_ff[PROD_BITS-1] ? PROD_BITS'(-x_ff) : PROD_BITS'(x_ff);

   assign div_req.start    = (state_ff == ST_SCALE);
   assign div_req.dividend = mag[FRAC +: VMAG_BITS];
   assign div_req.divisor  = lev_ff;

   bcrq_div #(
      .QUOT_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (quot)
   );

   // negative side clips at -1.0, positive side at the largest code
   always_comb begin
      if (neg_ff) begin
         ymag = (quot > (SAMPLE_BITS'(1) << FRAC)) ? (SAMPLE_BITS'(1) << FRAC) : quot;
         y_in = $signed(SAMPLE_BITS'(0) - ymag);
      end else begin
         ymag = quot;
         y_in = quot[FRAC] ? $signed((SAMPLE_BITS'(1) << FRAC) - SAMPLE_BITS'(1))
                           : $signed(quot);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         levels_ff    <= LEVEL_BITS'(32768);
         step_ff      <= STEP_BITS'(32'h1000_0000);
         for (int i = 0; i < CHANNELS; i++) begin
            phase_ff[i] <= '0;
            held_ff[i]  <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_QUANT_LEVELS: levels_ff <= csr_data[LEVEL_BITS-1:0];
               CSR_PHASE_STEP:   step_ff   <= csr_data[STEP_BITS-1:0];
               default:          ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff    <= idx_in;
                  sample_ff <= req_sample_in;
                  lev_ff    <= (levels_ff == '0) ? LEVEL_BITS'(1) : levels_ff;
                  state_ff  <= ST_PHASE;
               end
            end
            ST_PHASE: begin
               phase_ff[idx_ff] <= phase_sum[PHASE_BITS-1:0];
               if (capture) begin
                  held_ff[idx_ff] <= sample_ff;
                  h_ff            <= sample_ff;
               end else begin
                  h_ff <= held_ff[idx_ff];
               end
               state_ff <= ST_MULT;
            end
            ST_MULT: begin
               x_ff     <= prod;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               neg_ff   <= x_ff[PROD_BITS-1];
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  y_ff     <= y_in;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff       <= y_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_ff;

endmodule

FILE: src/bcrq_div.sv
// Shared compare-subtract unit: restoring divide, one quotient bit per cycle.
module bcrq_div #(
   parameter int QUOT_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bcrq_pkg::div_req_type   div_req,
   output logic                    div_done,
   output logic [QUOT_BITS-1:0]    div_quot
);
   import bcrq_pkg::*;

   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic [VMAG_BITS-1:0]  rem_ff;
   logic [LEVEL_BITS-1:0] dsr_ff;
   logic [QUOT_BITS-1:0]  quot_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  busy_ff;
   logic                  first_ff;
   logic                  done_ff;

   logic [VMAG_BITS-1:0]  cur;
   logic [VMAG_BITS-1:0]  dsr_ext;
   logic                  ge;

   // first step takes the integer part, later steps shift in a zero
   assign cur     = first_ff ? rem_ff : {rem_ff[VMAG_BITS-2:0], 1'b0};
   assign dsr_ext = {1'b0, dsr_ff};
   assign ge      = cur >= dsr_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff   <= div_req.dividend;
            dsr_ff   <= div_req.divisor;
            cnt_ff   <= CNT_BITS'(QUOT_BITS);
            busy_ff  <= 1'b1;
            first_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= ge ? (cur - dsr_ext) : cur;
            quot_ff  <= {quot_ff[QUOT_BITS-2:0], ge};
            first_ff <= 1'b0;
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

FILE: src/bcrq_checker.sv
// Port-level checker for the bitcrusher unit, bound to the top level.
module bcrq_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out
);

   // one item in flight: the channel closes right after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is still being worked on");

   // a result is only loaded at the end of an item's work
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in progress");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled result dropped or changed");

endmodule

bind bitcrush_rate_reduce_quantize_unit bcrq_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_bcrq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the bitcrusher rate reduce and quantise unit.
module tb_top;
   import bcrq_pkg::*;

   localparam int SAMPLE_BITS   = 24;
   localparam int LATENCY       = SAMPLE_BITS + 5;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 132;
   localparam int HOLDOFF_LEN   = 400;
   localparam longint unsigned FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);

   typedef struct packed {
      logic                   chan;
      logic [SAMPLE_BITS-1:0] sample;
   } audio_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_chan = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_write = 1'b0;
   csr_index_type                 csr_index = CSR_QUANT_LEVELS;
   logic [CSR_BITS-1:0]           csr_data = '0;

   // Predictor state
   logic [PHASE_BITS-1:0]         phase_acc [2];
   logic signed [SAMPLE_BITS-1:0] held_val [2];
   logic [LEVEL_BITS-1:0]         levels_reg;
   logic [STEP_BITS-1:0]          step_reg;

   audio_item_type                pend_q [$];
   logic signed [SAMPLE_BITS-1:0] crushed_q [$];
   audio_item_type                next_item;
   logic signed [SAMPLE_BITS-1:0] want;

   int send_idle_pct  = 32;
   int recv_stall_pct = 60;
   int n_accepted     = 0;
   int n_checked      = 0;
   int n_errors       = 0;
   int n_captures     = 0;
   int n_settings     = 0;
   int holdoff_left   = 0;
   bit holdoff_done   = 1'b0;
   int cycle_count    = 0;

   bitcrush_rate_reduce_quantize_unit #(
      .CHANNELS    (2),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_chan       (req_chan),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Scale by the level count, add a half, truncate towards zero, divide back, clip
   function automatic logic signed [SAMPLE_BITS-1:0] quantise(
         input logic signed [SAMPLE_BITS-1:0] h, input logic [LEVEL_BITS-1:0] lv);
      longint unsigned l;
      longint unsigned mag;
      longint unsigned ymag;
      longint          x;
      longint          y;
      l = (lv == '0) ? 64'd1 : 64'(lv);
      x = longint'(h) * longint'(l) + (longint'(1) <<< (SAMPLE_BITS - 2));
      mag = (x < 0) ? longint'(-x) : x;
      ymag = ((mag >> (SAMPLE_BITS - 1)) << (SAMPLE_BITS - 1)) / l;
      if (x < 0) begin
         if (ymag > FULL_SCALE)
            ymag = FULL_SCALE;
         y = -longint'(ymag);
      end else begin
         y = (ymag > FULL_SCALE - 1) ? longint'(FULL_SCALE - 1) : longint'(ymag);
      end
      return y[SAMPLE_BITS-1:0];
   endfunction

   function automatic void predict_item(input logic ch,
                                        input logic signed [SAMPLE_BITS-1:0] smp);
      longint unsigned s;
      s = 64'(phase_acc[ch]) + 64'(step_reg);
      if (s >= (64'd1 << PHASE_BITS)) begin
         held_val[ch] = smp;
         n_captures++;
      end
      phase_acc[ch] = s[PHASE_BITS-1:0];
      crushed_q.push_back(quantise(held_val[ch], levels_reg));
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_item(req_chan, req_sample_in);
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pend_q.pop_front();
               req_valid     <= 1'b1;
               req_chan      <= next_item.chan;
               req_sample_in <= next_item.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long output hold-off so the unit backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && n_accepted == 100) begin
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1'b1;
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (crushed_q.size() == 0) begin
               $error("unexpected item: sample_out %0d", rsp_sample_out);
               n_errors++;
            end else begin
               want = crushed_q.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample_out);
                  n_errors++;
               end
               n_checked++;
            end
         end
         rsp_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_regs(input logic [LEVEL_BITS-1:0] lv, input logic [STEP_BITS-1:0] st);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_QUANT_LEVELS;
      csr_data  <= {16'($urandom), lv};
      @(posedge clock);
      csr_index <= CSR_PHASE_STEP;
      csr_data  <= st;
      @(posedge clock);
      csr_write <= 1'b0;
      levels_reg = lv;
      step_reg   = st;
      n_settings++;
   endtask

   task automatic settle();
      while (pend_q.size() != 0 || req_valid || crushed_q.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   initial begin
      logic [LEVEL_BITS-1:0]  lv;
      logic [STEP_BITS-1:0]   st;
      logic [SAMPLE_BITS-1:0] smp;
      levels_reg  = 16'd32768;
      step_reg    = 32'h1000_0000;
      phase_acc   = '{default: '0};
      held_val    = '{default: '0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unity step, every item captured
      pend_q.push_back('{1'b0, 24'h000000});
      pend_q.push_back('{1'b0, 24'h800000});
      pend_q.push_back('{1'b1, 24'h7FFFFF});
      pend_q.push_back('{1'b1, 24'hFFFFFF});
      pend_q.push_back('{1'b0, 24'h000001});
      pend_q.push_back('{1'b1, 24'h400000});
      pend_q.push_back('{1'b0, 24'hC00000});
      pend_q.push_back('{1'b1, 24'h7FFF00});
      settle();

      // zero levels act as one; step far above 2.0
      write_regs(16'd0, 32'hFFFF_FFFF);
      pend_q.push_back('{1'b0, 24'h7FFFFF});
      pend_q.push_back('{1'b1, 24'h800000});
      pend_q.push_back('{1'b0, 24'h400000});
      pend_q.push_back('{1'b1, 24'hBFFFFF});
      pend_q.push_back('{1'b1, 24'hFFFFFF});
      settle();

      // largest level count, zero step: held values stay put
      write_regs(16'hFFFF, 32'h0000_0000);
      pend_q.push_back('{1'b0, 24'h123456});
      pend_q.push_back('{1'b1, 24'hEDCBA9});
      pend_q.push_back('{1'b0, 24'h800000});
      pend_q.push_back('{1'b1, 24'h7FFFFF});
      settle();

      // step of exactly 2.0, odd level count
      write_regs(16'd3, 32'h2000_0000);
      pend_q.push_back('{1'b0, 24'h2AAAAA});
      pend_q.push_back('{1'b1, 24'hD55556});
      pend_q.push_back('{1'b0, 24'h7FFFFF});
      pend_q.push_back('{1'b1, 24'h800000});
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES / 3) begin
            send_idle_pct  = 60;
            recv_stall_pct = 32;
         end
         if (p == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         case ($urandom_range(7))
            0: lv = 16'd0;
            1: lv = 16'd1;
            2: lv = 16'hFFFF;
            3: lv = 16'd1 << $urandom_range(15);
            4: lv = 16'($urandom_range(64, 2));
            default: lv = 16'($urandom);
         endcase
         case ($urandom_range(9))
            0: st = 32'h0000_0000;
            1: st = 32'hFFFF_FFFF;
            2: st = 32'h1000_0000;
            3, 4: st = 32'($urandom_range(32'h1000_0000, 1));
            5, 6: st = 32'($urandom_range(32'h0800_0000, 32'h0100_0000));
            default: st = $urandom;
         endcase
         write_regs(lv, st);
         repeat (PHASE_ITEMS) begin
            case ($urandom_range(9))
               0: smp = 24'h800000;
               1: smp = 24'h7FFFFF;
               2: smp = 24'($signed($urandom_range(512)) - 256);
               default: smp = 24'($urandom);
            endcase
            pend_q.push_back('{1'($urandom_range(1)), smp});
         end
         settle();
      end

      $display("Checked %0d crushed samples over %0d register settings (%0d captures),",
               n_checked, n_settings, n_captures);
      $display("with sender and receiver idling in turn and a %0d-cycle output hold-off.",
               HOLDOFF_LEN);
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: bitcrush_rate_reduce_quantize_unit.f
src/bcrq_pkg.sv
src/bcrq_div.sv
src/bitcrush_rate_reduce_quantize_unit.sv
src/bcrq_checker.sv
dv/tb_top.sv
